>>> rtl/patd_pkg.sv
// ============================================================================
// patd_pkg: shared types and constants for the poly-A tail detector
// Command codes, register indexes, window offsets and hexamer patterns.
// ============================================================================
`default_nettype none

package patd_pkg;

  // Position width; positions wrap at this many bits.
  localparam int POS_W     = 32;
  // Width of the aligned end position field on the stream.
  localparam int GEN_END_W = 32;
  localparam int BASE_W    = 8;
  localparam int NEED_W    = 4;
  localparam int HEX_W     = 48;
  localparam int WIN_W     = HEX_W - BASE_W;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_EST    = 2'd1,
    CMD_GEN    = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_EST_NEED  = 2'd0,
    CFG_RUN_NEED  = 2'd1,
    CFG_DOWN_NEED = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_t;

  localparam logic [NEED_W-1:0] EST_NEED_RST  = NEED_W'(8);
  localparam logic [NEED_W-1:0] RUN_NEED_RST  = NEED_W'(6);
  localparam logic [NEED_W-1:0] DOWN_NEED_RST = NEED_W'(7);

  // Window offsets around the aligned end.
  localparam int HEX_BACK  = 39;
  localparam int HEX_SPAN  = 5;
  localparam int RUN_BACK  = 9;
  localparam int AHEAD     = 10;

  localparam logic [HEX_W-1:0] HEX_AATAAA_UP = 48'h414154414141;
  localparam logic [HEX_W-1:0] HEX_ATTAAA_UP = 48'h415454414141;
  localparam logic [HEX_W-1:0] HEX_AATAAA_LO = 48'h616174616161;
  localparam logic [HEX_W-1:0] HEX_ATTAAA_LO = 48'h617474616161;

  localparam logic [BASE_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [BASE_W-1:0] CHAR_A_LO = 8'h61;

  // One accepted beat as seen by the tracking units.
  typedef struct packed {
    logic                 start;
    logic                 est;
    logic                 gen;
    logic [BASE_W-1:0]    base;
    logic [POS_W-1:0]     end_pos;
  } patd_beat_t;

  // Genomic window findings.
  typedef struct packed {
    logic hex_seen;
    logic run_hit;
    logic down_hit;
  } patd_gen_status_t;

  function automatic logic is_a(input logic [BASE_W-1:0] b);
    return (b == CHAR_A_UP) || (b == CHAR_A_LO);
  endfunction

endpackage

`default_nettype wire

>>> rtl/polya_tail_detector.sv
// ============================================================================
// polya_tail_detector: genuine poly-A tail decision per transcript end
// Streams EST and genomic bytes around an aligned end and reports the verdict.
// ============================================================================
//
//  Channel   Dir  Fields (low bit up)                       Beat meaning
//  --------  ---  ----------------------------------------  ---------------------
//  s_*       in   tdata: base[7:0] gen_end[39:8]; tuser cmd  start/EST/genomic/finish
//  m_*       out  tdata: is_polya[0] pas_found[1] (zeros)    one verdict per finish
//  cfg_*     in   index 0..2, data 4 bits                    register write
//
// Every input beat is absorbed on acceptance; the state registers update at the
// accepting edge, so a new beat can follow in the next cycle. A finish beat
// loads the output register and the verdict is offered on the next cycle.
// The input side stalls only while a verdict waits in the output register and
// the sink is not taking it; the output register is the only element parting the
// two sides. Reset is synchronous and returns the registers to 8, 6 and 7, the
// bounds hex_lo, hex_hi, ahead_hi to 5, 5, 10 and other per-call state to zero.
// ============================================================================
`default_nettype none

module polya_tail_detector (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input stream.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // base[7:0], gen_end[39:8]
  input  wire logic [patd_pkg::BASE_W+patd_pkg::GEN_END_W-1:0] s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]                         s_tuser,
  // Result stream.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // is_polya[0], pas_found[1], zeros [7:2]
  output logic [7:0]                              m_tdata,
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [patd_pkg::NEED_W-1:0]        cfg_data
);

  logic [patd_pkg::NEED_W-1:0] est_need;
  logic [patd_pkg::NEED_W-1:0] run_need;
  logic [patd_pkg::NEED_W-1:0] down_need;

  logic                        s_fire;
  patd_pkg::cmd_t              cmd;
  patd_pkg::patd_beat_t        beat;
  patd_pkg::patd_gen_status_t  gen_status;
  logic                        est_pass;
  logic [patd_pkg::GEN_END_W+patd_pkg::POS_W-1:0] end_wide;

  // Configuration registers: user writes only while block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      est_need  <= patd_pkg::EST_NEED_RST;
      run_need  <= patd_pkg::RUN_NEED_RST;
      down_need <= patd_pkg::DOWN_NEED_RST;
    end else if (cfg_we) begin
      case (patd_pkg::cfg_index_t'(cfg_index))
        patd_pkg::CFG_EST_NEED:  est_need  <= cfg_data;
        patd_pkg::CFG_RUN_NEED:  run_need  <= cfg_data;
        patd_pkg::CFG_DOWN_NEED: down_need <= cfg_data;
        default: ;
      endcase
    end
  end

  // A beat is taken whenever no verdict is stuck in the output register.
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign cmd      = patd_pkg::cmd_t'(s_tuser);

  // The end position is zero-extended or truncated to the position width.
  assign end_wide = {{patd_pkg::POS_W{1'b0}},
                     s_tdata[patd_pkg::BASE_W +: patd_pkg::GEN_END_W]};

  assign beat.start   = s_fire && (cmd == patd_pkg::CMD_START);
  assign beat.est     = s_fire && (cmd == patd_pkg::CMD_EST);
  assign beat.gen     = s_fire && (cmd == patd_pkg::CMD_GEN);
  assign beat.base    = s_tdata[patd_pkg::BASE_W-1:0];
  assign beat.end_pos = end_wide[patd_pkg::POS_W-1:0];

  patd_est u_est (
    .clk      (clk),
    .rst      (rst),
    .beat     (beat),
    .est_need (est_need),
    .est_pass (est_pass)
  );

  patd_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .run_need  (run_need),
    .down_need (down_need),
    .status    (gen_status)
  );

  // Output register. The finish beat reads the state as it stands before the
  // edge, which already holds every beat accepted earlier.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire && (cmd == patd_pkg::CMD_FINISH)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && (cmd == patd_pkg::CMD_FINISH)) begin
      m_tdata <= {6'b0,
                  est_pass && gen_status.hex_seen,
                  est_pass && !gen_status.run_hit && !gen_status.down_hit};
    end
  end

endmodule

`default_nettype wire

>>> rtl/patd_est.sv
// ============================================================================
// patd_est: EST remainder checker
// Counts leading A bytes of the EST remainder and decides pass or fail.
// ============================================================================
`default_nettype none

module patd_est (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire patd_pkg::patd_beat_t          beat,
  input  wire logic [patd_pkg::NEED_W-1:0]   est_need,
  output logic                               est_pass
);

  logic [patd_pkg::NEED_W-1:0] a_count;
  logic [patd_pkg::NEED_W-1:0] a_count_next;
  logic                        closed;
  logic                        closed_next;
  logic                        pass;
  logic                        pass_next;

  always_comb begin
    a_count_next = a_count;
    closed_next  = closed;
    pass_next    = pass;
    if (beat.start) begin
      a_count_next = '0;
      closed_next  = 1'b0;
      pass_next    = 1'b0;
    end else if (beat.est && !closed && !pass) begin
      if (a_count >= est_need) begin
        pass_next   = 1'b1;
        closed_next = 1'b1;
      end else if (patd_pkg::is_a(beat.base)) begin
        a_count_next = a_count + 1'b1;
      end else begin
        closed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count <= '0;
      closed  <= 1'b0;
      pass    <= 1'b0;
    end else begin
      a_count <= a_count_next;
      closed  <= closed_next;
      pass    <= pass_next;
    end
  end

  assign est_pass = pass;

endmodule

`default_nettype wire

>>> rtl/patd_gen.sv
// ============================================================================
// patd_gen: genomic window tracker
// Keeps the genomic position, the hexamer shift window and the priming counts.
// ============================================================================
`default_nettype none

module patd_gen (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire patd_pkg::patd_beat_t          beat,
  input  wire logic [patd_pkg::NEED_W-1:0]   run_need,
  input  wire logic [patd_pkg::NEED_W-1:0]   down_need,
  output patd_pkg::patd_gen_status_t         status
);

  localparam int BW = patd_pkg::POS_W + 1;

  // Window bounds are kept one bit wider so that they never wrap.
  logic [patd_pkg::POS_W-1:0] end_pos;
  logic [BW-1:0]              hex_lo;
  logic [BW-1:0]              hex_hi;
  logic [BW-1:0]              run_lo;
  logic [BW-1:0]              ahead_hi;
  logic [patd_pkg::POS_W-1:0] pos;
  logic [patd_pkg::WIN_W-1:0] window;
  logic                       hex_seen;
  logic [patd_pkg::NEED_W-1:0] run_len;
  logic                       run_hit;
  logic [patd_pkg::NEED_W-1:0] down_cnt;
  logic                       down_hit;

  logic [patd_pkg::POS_W-1:0]  pos_next;
  logic [patd_pkg::WIN_W-1:0]  window_next;
  logic                        hex_seen_next;
  logic [patd_pkg::NEED_W-1:0] run_len_next;
  logic                        run_hit_next;
  logic [patd_pkg::NEED_W-1:0] down_cnt_next;
  logic                        down_hit_next;

  logic [BW-1:0]              new_end;
  logic [BW-1:0]              new_first;
  logic [BW-1:0]              new_run_lo;
  logic [BW-1:0]              cur_pos;
  logic [patd_pkg::HEX_W-1:0] six;
  logic                       in_hex;
  logic                       in_run;
  logic                       in_down;
  logic                       base_a;

  assign new_end    = {1'b0, beat.end_pos};
  assign new_first  = (new_end < BW'(patd_pkg::HEX_BACK)) ? '0
                                                          : new_end - BW'(patd_pkg::HEX_BACK);
  assign new_run_lo = (new_end < BW'(patd_pkg::RUN_BACK)) ? '0
                                                          : new_end - BW'(patd_pkg::RUN_BACK);

  assign cur_pos = {1'b0, pos};
  assign six     = {window, beat.base};
  assign base_a  = patd_pkg::is_a(beat.base);
  assign in_hex  = (cur_pos >= hex_lo) && (cur_pos <= hex_hi);
  assign in_run  = (cur_pos >= run_lo) && (cur_pos <= ahead_hi);
  assign in_down = (cur_pos > {1'b0, end_pos}) && (cur_pos <= ahead_hi);

  always_comb begin
    pos_next      = pos;
    window_next   = window;
    hex_seen_next = hex_seen;
    run_len_next  = run_len;
    run_hit_next  = run_hit;
    down_cnt_next = down_cnt;
    down_hit_next = down_hit;
    if (beat.start) begin
      pos_next      = new_first[patd_pkg::POS_W-1:0];
      window_next   = '0;
      hex_seen_next = 1'b0;
      run_len_next  = '0;
      run_hit_next  = 1'b0;
      down_cnt_next = '0;
      down_hit_next = 1'b0;
    end else if (beat.gen) begin
      if (in_hex && ((six == patd_pkg::HEX_AATAAA_UP) || (six == patd_pkg::HEX_ATTAAA_UP) ||
                     (six == patd_pkg::HEX_AATAAA_LO) || (six == patd_pkg::HEX_ATTAAA_LO))) begin
        hex_seen_next = 1'b1;
      end
      if (!run_hit && in_run) begin
        if (run_len >= run_need) begin
          run_hit_next = 1'b1;
        end else if (base_a) begin
          run_len_next = run_len + 1'b1;
        end else begin
          run_len_next = '0;
        end
      end
      if (!down_hit && in_down) begin
        if (down_cnt >= down_need) begin
          down_hit_next = 1'b1;
        end else if (base_a) begin
          down_cnt_next = down_cnt + 1'b1;
        end
      end
      window_next = six[patd_pkg::WIN_W-1:0];
      pos_next    = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_pos  <= '0;
      hex_lo   <= BW'(patd_pkg::HEX_SPAN);
      hex_hi   <= BW'(patd_pkg::HEX_SPAN);
      run_lo   <= '0;
      ahead_hi <= BW'(patd_pkg::AHEAD);
      pos      <= '0;
      window   <= '0;
      hex_seen <= 1'b0;
      run_len  <= '0;
      run_hit  <= 1'b0;
      down_cnt <= '0;
      down_hit <= 1'b0;
    end else begin
      if (beat.start) begin
        end_pos  <= beat.end_pos;
        hex_lo   <= new_first + BW'(patd_pkg::HEX_SPAN);
        hex_hi   <= new_end + BW'(patd_pkg::HEX_SPAN);
        run_lo   <= new_run_lo;
        ahead_hi <= new_end + BW'(patd_pkg::AHEAD);
      end
      pos      <= pos_next;
      window   <= window_next;
      hex_seen <= hex_seen_next;
      run_len  <= run_len_next;
      run_hit  <= run_hit_next;
      down_cnt <= down_cnt_next;
      down_hit <= down_hit_next;
    end
  end

  assign status.hex_seen = hex_seen;
  assign status.run_hit  = run_hit;
  assign status.down_hit = down_hit;

endmodule

`default_nettype wire

>>> rtl/patd_checker.sv
// ============================================================================
// patd_checker: port-level checks for the poly-A tail detector
// Watches the stream handshakes and the verdict beats over time.
// ============================================================================
`default_nettype none

module patd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata
);

  logic finish_fire;
  assign finish_fire = s_tvalid && s_tready && (s_tuser == patd_pkg::CMD_FINISH);

  // A stalled verdict holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("verdict changed while stalled");

  // Every accepted finish beat is followed by a verdict.
  assert property (@(posedge clk) disable iff (rst)
    finish_fire |=> m_tvalid)
    else $error("finish beat produced no verdict");

  // No verdict appears without a finish beat behind it.
  assert property (@(posedge clk) disable iff (rst)
    ((!m_tvalid || m_tready) && !finish_fire) |=> !m_tvalid)
    else $error("verdict without finish beat");

  // The input side only stalls behind a waiting verdict.
  assert property (@(posedge clk) disable iff (rst)
    (!s_tready) |-> (m_tvalid && !m_tready))
    else $error("input stalled with free output");

endmodule

bind polya_tail_detector patd_checker u_patd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
